FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WordW = 32;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_INIT  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } t_out_word;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[r];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

endpackage

FILE: rtl/sha_sched.sv
// ----------------------------------------------------------------------------
// sha_sched
// Message schedule memory: 16 x 32 window, four synchronous read ports
// (one bank copy each), one write port. Computes W for each round.
// ----------------------------------------------------------------------------
module sha_sched (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [5:0]  i_round,
    output logic [31:0] o_w
);
    import sha_pkg::*;

    logic [31:0] r_m0 [16];
    logic [31:0] r_m1 [16];
    logic [31:0] r_m2 [16];
    logic [31:0] r_m3 [16];
    logic [31:0] r_x16, r_x15, r_x7, r_x2;
    logic [31:0] g0, g1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_m0[i_waddr] <= i_wdata;
            r_m1[i_waddr] <= i_wdata;
            r_m2[i_waddr] <= i_wdata;
            r_m3[i_waddr] <= i_wdata;
        end
        r_x16 <= r_m0[i_round[3:0]];
        r_x15 <= r_m1[i_round[3:0] + 4'd1];
        r_x7  <= r_m2[i_round[3:0] + 4'd9];
        r_x2  <= r_m3[i_round[3:0] + 4'd14];
    end

    assign g0  = rotr(r_x15, 7) ^ rotr(r_x15, 18) ^ (r_x15 >> 3);
    assign g1  = rotr(r_x2, 17) ^ rotr(r_x2, 19) ^ (r_x2 >> 10);
    assign o_w = r_x16 + g0 + r_x7 + g1;
endmodule

FILE: rtl/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round
// Working variables and one compression round per cycle while i_step is high.
// ----------------------------------------------------------------------------
module sha_round (
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [255:0] i_chain,
    input  logic        i_step,
    input  logic [31:0] i_w,
    input  logic [5:0]  i_round,
    output logic [255:0] o_vars
);
    import sha_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] s1, ch, t1, s0, mj;

    assign s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1 = r_v[7] + s1 + ch + round_k(i_round) + i_w;
    assign s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= i_chain[255 - 32*i -: 32];
        end else if (i_step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + s0 + mj;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_vars[255 - 32*i -: 32] = r_v[i];
    end
endmodule

FILE: rtl/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine
// Streaming SHA-256: message words in, eight digest words out per message.
// ----------------------------------------------------------------------------
// Each full message word is written into the schedule memory when accepted; the
// sixteenth word of a block starts a compression (load with the first schedule
// read, 64 rounds on the one round unit, chain update), during which no word is
// accepted. On the last word the padding words are written one per cycle (up to
// 18, with an extra compression if the length does not fit), then the eight
// digest words are offered one per cycle while m_axis_tready is high. No
// clearing pass after reset.
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [2:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // digest_done
);
    import sha_pkg::*;

    t_state       r_state, n_state;
    logic [31:0]  r_chain [8];
    logic [63:0]  r_len;
    logic [3:0]   r_pos;
    logic [6:0]   r_rnd;
    logic         r_pad_first, r_padding, r_spill;
    logic [2:0]   r_nb;
    logic [31:0]  r_msg;
    logic [2:0]   r_oidx;
    logic         we;
    logic [3:0]   waddr;
    logic [31:0]  wdata, w_sched, w_round, pad_word, mask;
    logic [5:0]   rd_round;
    logic [255:0] chain_flat, vars;
    logic         acc, step, load;

    assign s_axis_tready = r_state == ST_LOAD;
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign load = r_state == ST_INIT;
    assign step = r_state == ST_ROUND;

    always_comb begin
        for (int i = 0; i < 8; i++) chain_flat[255 - 32*i -: 32] = r_chain[i];
    end

    // rounds 0..15 read W direct from memory, the read for round r+1 issued now
    assign rd_round = (r_state == ST_INIT) ? 6'd0 : r_rnd[5:0] + 6'd1;

    always_comb begin
        mask = (r_nb == 3'd0) ? 32'd0 : (32'hffffffff << (6'd32 - {r_nb, 3'b000}));
        if (r_pad_first) begin
            if (r_nb == 3'd4) pad_word = 32'h80000000;
            else pad_word = (r_msg & mask) | (32'h80 << (5'd24 - {r_nb[1:0], 3'b000}));
        end else if (r_pos == 4'd14 && r_padding && !r_spill) pad_word = r_len[63:32];
        else if (r_pos == 4'd15 && r_padding && !r_spill) pad_word = r_len[31:0];
        else pad_word = 32'd0;
    end

    always_comb begin
        we = 1'b0; waddr = r_pos; wdata = pad_word;
        if (acc && !(s_axis_tlast && s_axis_tuser < 3'd4 && s_axis_tuser != 3'd4
                     && !(s_axis_tuser > 3'd4))) begin
            we = 1'b1; wdata = s_axis_tdata;
        end else if (r_state == ST_PAD) begin
            we = 1'b1;
        end else if (step && r_rnd[5:4] != 2'b00) begin
            we = 1'b1; waddr = r_rnd[3:0]; wdata = w_sched;
        end
    end

    sha_sched u_sched (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_round(rd_round - 6'd16 + 6'd16), .o_w(w_sched)
    );

    logic [31:0] r_wdir [16];
    logic [31:0] r_wd;
    always_ff @(posedge i_clk) begin
        if (we) r_wdir[waddr] <= wdata;
        r_wd <= r_wdir[rd_round[3:0]];
    end
    assign w_round = (r_rnd[5:4] == 2'b00) ? r_wd : w_sched;

    sha_round u_round (
        .i_clk(i_clk), .i_load(load), .i_chain(chain_flat), .i_step(step),
        .i_w(w_round), .i_round(r_rnd[5:0]), .o_vars(vars)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (acc) begin
                if (r_pos == 4'd15 && (!s_axis_tlast || s_axis_tuser >= 3'd4))
                    n_state = ST_INIT;
                else if (s_axis_tlast) n_state = ST_PAD;
            end
            ST_PAD:   if (r_pos == 4'd15) n_state = ST_INIT;
            ST_INIT:  n_state = ST_ROUND;
            ST_ROUND: if (r_rnd == 7'd63) n_state = ST_FOLD;
            ST_FOLD:  n_state = r_padding ? (r_pos == 4'd0 && r_len[0] ? ST_OUT : ST_PAD)
                                          : ST_LOAD;
            ST_OUT:   if (m_axis_tready && r_oidx == 3'd7) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    // r_len[0] is never set by data (bit counts are multiples of 8); it marks
    // the compression holding the length words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_len <= '0; r_pos <= '0; r_rnd <= '0;
            r_pad_first <= 1'b0; r_padding <= 1'b0; r_spill <= 1'b0; r_oidx <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= init_h(3'(i));
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: if (acc) begin
                    r_msg <= s_axis_tdata;
                    if (s_axis_tlast) begin
                        r_nb <= (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
                        r_len <= r_len + {58'd0, ((s_axis_tuser > 3'd4) ? 3'd4
                                 : s_axis_tuser), 3'b000};
                        r_pad_first <= 1'b1; r_padding <= 1'b1;
                        if ((s_axis_tuser >= 3'd4)) r_pos <= r_pos + 4'd1;
                    end else begin
                        r_len <= r_len + 64'd32;
                        r_pos <= r_pos + 4'd1;
                    end
                end
                ST_PAD: begin
                    r_pad_first <= 1'b0;
                    r_pos <= r_pos + 4'd1;
                    if (r_pad_first && r_pos >= 4'd14) r_spill <= 1'b1;
                    if (r_pos == 4'd15 && !r_pad_first && !r_spill)
                        r_len[0] <= 1'b1;
                end
                ST_ROUND: r_rnd <= r_rnd + 7'd1;
                ST_FOLD: begin
                    r_rnd <= '0;
                    r_spill <= 1'b0;
                    for (int i = 0; i < 8; i++)
                        r_chain[i] <= r_chain[i] + vars[255 - 32*i -: 32];
                end
                ST_OUT: if (m_axis_tready) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        r_len <= '0; r_pos <= '0; r_padding <= 1'b0;
                        for (int i = 0; i < 8; i++) r_chain[i] <= init_h(3'(i));
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_state == ST_OUT;
    assign m_axis_tdata  = r_chain[r_oidx];
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = r_oidx == 3'd7;

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("output while loading");
    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> r_rnd < 7'd64) else $error("round overrun");
    a_tready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |=> !m_axis_tvalid || r_padding) else $error("early digest");
endmodule

FILE: tb/sha256_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_checker
// Watches both streams of the hash engine, computes each expected digest from
// the accepted message words and compares every digest word field by field.
// ----------------------------------------------------------------------------
module sha256_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [2:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,   // last_word
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // digest_word
    input  logic [2:0]  m_axis_tuser,   // word_index
    input  logic        m_axis_tlast,   // digest_done
    output int          o_errors,
    output int          o_pending,
    output int          o_digests
);
    import sha_pkg::*;

    logic [31:0] hash_state [8];
    logic [31:0] block_buf [16];
    logic [63:0] msg_bits;
    int unsigned slot;
    t_out_word   digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    task automatic clear_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = init_h(i[2:0]);
        msg_bits = '0;
        slot = 0;
    endtask

    task automatic compress();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic push_word(input logic [31:0] w);
        block_buf[slot] = w;
        slot++;
        if (slot == 16) begin
            compress();
            slot = 0;
        end
    endtask

    task automatic absorb(input logic [31:0] data, input logic [2:0] nbytes,
                          input logic is_last);
        logic [31:0] mask;
        int n;
        t_out_word o;
        if (!is_last) begin
            msg_bits += 32;
            push_word(data);
            return;
        end
        n = (nbytes > 4) ? 4 : nbytes;
        msg_bits += n * 8;
        if (n == 4) begin
            push_word(data);
            push_word(32'h8000_0000);
        end else begin
            mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
            push_word((data & mask) | (32'h80 << (24 - 8 * n)));
        end
        if (slot > 14) while (slot != 0) push_word(32'h0);
        while (slot < 14) push_word(32'h0);
        push_word(msg_bits[63:32]);
        push_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) begin
            o.digest_word = hash_state[i];
            o.word_index  = i[2:0];
            o.digest_done = (i == 7);
            digest_q.push_back(o);
        end
        clear_hash();
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_digests = 0;
        clear_hash();
    end

    assign o_pending = digest_q.size();

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    report("unexpected digest word", m_axis_tdata, 32'h0);
                end else begin
                    e = digest_q.pop_front();
                    if (m_axis_tdata !== e.digest_word)
                        report("digest_word", m_axis_tdata, e.digest_word);
                    if (m_axis_tuser !== e.word_index)
                        report("word_index", m_axis_tuser, e.word_index);
                    if (m_axis_tlast !== e.digest_done)
                        report("digest_done", m_axis_tlast, e.digest_done);
                    if (e.digest_done) o_digests++;
                end
            end
        end
    end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives messages of many lengths and tail byte counts into the hash engine
// under random idling and back pressure; the checker verifies every digest.
// ----------------------------------------------------------------------------
module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // message_word
    logic [2:0]  s_axis_tuser = '0;   // valid_bytes
    logic        s_axis_tlast = 1'b0; // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // digest_word
    logic [2:0]  m_axis_tuser;        // word_index
    logic        m_axis_tlast;        // digest_done
    int          errors, pending, digests;
    int          words_sent = 0;
    bit          calm = 1'b0;
    int          hold_off = 0;

    always #4 i_clk = ~i_clk;

    sha256_hash_engine dut (.*);
    sha256_checker chk (.*, .o_errors(errors), .o_pending(pending),
                        .o_digests(digests));

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    task automatic send(input logic [31:0] data, input logic [2:0] nb,
                        input logic is_last);
        while (!calm && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= nb;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_message(input int n_full, input logic [2:0] tail_nb,
                                input logic [31:0] tail_data);
        for (int i = 0; i < n_full; i++)
            send($urandom, 3'($urandom), 1'b0);
        send(tail_data, tail_nb, 1'b1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, every tail count, block-boundary lengths
        for (int nb = 0; nb < 8; nb++) send_message(0, nb[2:0], $urandom);
        send_message(0, 3'd4, 32'hffff_ffff);
        send_message(0, 3'd4, 32'h0);
        send_message(13, 3'd4, $urandom);
        send_message(13, 3'd1, $urandom);
        send_message(14, 3'd0, $urandom);
        send_message(15, 3'd3, $urandom);
        send_message(15, 3'd4, $urandom);
        drain();
        // receiver held off while a long message keeps coming
        hold_off = 300;
        send_message(40, 3'd2, $urandom);
        drain();
        calm = 1'b1;
        for (int i = 0; i < 4; i++) send_message($urandom_range(20), 3'($urandom), $urandom);
        calm = 1'b0;
        while (words_sent < 340) begin
            if ($urandom_range(9) == 0)
                send_message($urandom_range(40), 3'($urandom), $urandom);
            else
                send_message($urandom_range(18), 3'($urandom_range(4)), $urandom);
        end
        drain();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d message words and %0d digests, all tail byte counts,",
                 words_sent, digests);
        $display("block-boundary lengths, random idling and a long output stall.");
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
